/* hdl/hex_text_table_parser_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the hex text table parser
// Concurrent assertion helpers that can be compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef HEX_TEXT_TABLE_PARSER_MACROS_SVH
`define HEX_TEXT_TABLE_PARSER_MACROS_SVH

`ifndef ASSERT_OFF
// Checked at every rising edge once reset has been released.
`define HEXP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// Checked at every rising edge, reset included.
`define HEXP_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define HEXP_ASSERT(label, clk, rst_n, prop)
`define HEXP_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

/* hdl/hexp_pkg.sv */
// ----------------------------------------------------------------------------
// hexp_pkg
// Shared constants, types and character helpers for the hex table parser.
// ----------------------------------------------------------------------------
package hexp_pkg;

    localparam int HEXP_ENTRIES_PER_LINE = 16;
    localparam int HEXP_TABLE_ENTRIES    = 256;

    // Item kinds on the input side.
    localparam logic [1:0] KIND_CHAR    = 2'd0;
    localparam logic [1:0] KIND_RESTART = 2'd1;
    localparam logic [1:0] KIND_END     = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_BYTE      = 2'd0;
    localparam logic [1:0] ST_FORMAT    = 2'd1;
    localparam logic [1:0] ST_DONE      = 2'd2;
    localparam logic [1:0] ST_PREMATURE = 2'd3;

    localparam logic [7:0] CH_0       = 8'h30;
    localparam logic [7:0] CH_9       = 8'h39;
    localparam logic [7:0] CH_A       = 8'h41;
    localparam logic [7:0] CH_F       = 8'h46;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] HEX_TEN    = 8'd10;

    typedef enum logic [2:0] {
        PH_HIGH = 3'b001,
        PH_LOW  = 3'b010,
        PH_SEP  = 3'b100
    } phase_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] byte_value;
        logic [7:0] entry_index;
    } res_t;

    function automatic logic digit_ok(input logic [7:0] c);
        return c inside {[CH_0:CH_9], [CH_A:CH_F]};
    endfunction

    function automatic logic [3:0] digit_value(input logic [7:0] c);
        logic [7:0] d;
        d = (c < CH_A) ? (c - CH_0) : (c - CH_A + HEX_TEN);
        return d[3:0];
    endfunction

endpackage

/* hdl/hexp_parse_core.sv */
// ----------------------------------------------------------------------------
// hexp_parse_core
// Input register, parser state and the combinational character decode.
// ----------------------------------------------------------------------------
`include "hex_text_table_parser_macros.svh"

module hexp_parse_core #(
    parameter int ENTRIES_PER_LINE = hexp_pkg::HEXP_ENTRIES_PER_LINE,
    parameter int TABLE_ENTRIES    = hexp_pkg::HEXP_TABLE_ENTRIES
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [1:0]     kind,
    input  logic [7:0]     char_code,
    input  logic           out_ready,
    output logic           res_valid,
    output hexp_pkg::res_t res
);
    import hexp_pkg::*;

    localparam int POS_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int COL_W = (ENTRIES_PER_LINE > 1) ? $clog2(ENTRIES_PER_LINE) : 1;

    logic             item_valid_reg, item_valid_next;
    logic [1:0]       kind_reg, kind_next;
    logic [7:0]       char_reg, char_next;
    phase_t           phase_reg, phase_next;
    logic [3:0]       high_nibble_reg, high_nibble_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic             stopped_reg, stopped_next;

    logic             proc_en;
    logic             last_entry;
    logic             line_end;
    logic [7:0]       want_sep;
    logic [POS_W+7:0] pos_wide;
    logic             res_is_byte;

    assign proc_en  = item_valid_reg && out_ready;
    assign in_ready = !item_valid_reg || out_ready;

    assign last_entry = (pos_reg == POS_W'(TABLE_ENTRIES - 1));
    assign line_end   = last_entry || (col_reg == COL_W'(ENTRIES_PER_LINE - 1));
    assign want_sep   = line_end ? CH_NEWLINE : CH_SPACE;
    assign pos_wide   = {8'd0, pos_reg};

    assign res_is_byte = res_valid && (res.status == ST_BYTE);

    always_comb
    begin
        item_valid_next  = item_valid_reg;
        kind_next        = kind_reg;
        char_next        = char_reg;
        phase_next       = phase_reg;
        high_nibble_next = high_nibble_reg;
        pos_next         = pos_reg;
        col_next         = col_reg;
        stopped_next     = stopped_reg;
        res_valid        = 1'b0;
        res              = '0;

        if (in_ready)
        begin
            item_valid_next = in_valid;
            if (in_valid)
            begin
                kind_next = kind;
                char_next = char_code;
            end
        end

        if (proc_en)
        begin
            case (kind_reg)
                KIND_RESTART:
                begin
                    phase_next       = PH_HIGH;
                    high_nibble_next = 4'd0;
                    pos_next         = '0;
                    col_next         = '0;
                    stopped_next     = 1'b0;
                end
                KIND_END:
                begin
                    if (!stopped_reg)
                    begin
                        stopped_next = 1'b1;
                        res_valid    = 1'b1;
                        res.status   = ST_PREMATURE;
                    end
                end
                KIND_CHAR:
                begin
                    if (!stopped_reg)
                    begin
                        case (phase_reg)
                            PH_HIGH:
                            begin
                                if (digit_ok(char_reg))
                                begin
                                    high_nibble_next = digit_value(char_reg);
                                    phase_next       = PH_LOW;
                                end
                                else
                                begin
                                    stopped_next = 1'b1;
                                    res_valid    = 1'b1;
                                    res.status   = ST_FORMAT;
                                end
                            end
                            PH_LOW:
                            begin
                                res_valid = 1'b1;
                                if (digit_ok(char_reg))
                                begin
                                    res.status      = ST_BYTE;
                                    res.byte_value  = {high_nibble_reg, digit_value(char_reg)};
                                    res.entry_index = pos_wide[7:0];
                                    phase_next      = PH_SEP;
                                end
                                else
                                begin
                                    stopped_next = 1'b1;
                                    res.status   = ST_FORMAT;
                                end
                            end
                            PH_SEP:
                            begin
                                if (char_reg != want_sep)
                                begin
                                    stopped_next = 1'b1;
                                    res_valid    = 1'b1;
                                    res.status   = ST_FORMAT;
                                end
                                else
                                begin
                                    phase_next = PH_HIGH;
                                    if (last_entry)
                                    begin
                                        // The newline after the final entry closes the table.
                                        stopped_next = 1'b1;
                                        res_valid    = 1'b1;
                                        res.status   = ST_DONE;
                                    end
                                    else
                                    begin
                                        pos_next = pos_reg + POS_W'(1);
                                        col_next = line_end ? '0 : col_reg + COL_W'(1);
                                    end
                                end
                            end
                            default:
                            begin
                                phase_next = PH_HIGH;
                            end
                        endcase
                    end
                end
                default:
                begin
                    // Unused kind code: dropped without a result.
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg  <= 1'b0;
            phase_reg       <= PH_HIGH;
            high_nibble_reg <= 4'd0;
            pos_reg         <= '0;
            col_reg         <= '0;
            stopped_reg     <= 1'b0;
        end
        else
        begin
            item_valid_reg  <= item_valid_next;
            phase_reg       <= phase_next;
            high_nibble_reg <= high_nibble_next;
            pos_reg         <= pos_next;
            col_reg         <= col_next;
            stopped_reg     <= stopped_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        char_reg <= char_next;
    end

    `HEXP_ASSERT(a_res_only_when_room, clk, rst_n, res_valid |-> out_ready)
    `HEXP_ASSERT(a_stopped_is_silent, clk, rst_n, stopped_reg |-> !res_valid)
    `HEXP_ASSERT(a_non_byte_stops, clk, rst_n, (res_valid && !res_is_byte) |=> stopped_reg)
    `HEXP_ASSERT(a_byte_then_sep, clk, rst_n, res_is_byte |=> (phase_reg == PH_SEP))

endmodule

/* hdl/hexp_out_buf.sv */
// ----------------------------------------------------------------------------
// hexp_out_buf
// Result register with a skid stage so the ready toward the parser is registered.
// ----------------------------------------------------------------------------
`include "hex_text_table_parser_macros.svh"

module hexp_out_buf (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           res_valid,
    output logic           res_ready,
    input  hexp_pkg::res_t res,
    output logic           out_valid,
    input  logic           out_ready,
    output hexp_pkg::res_t out_res
);
    import hexp_pkg::*;

    logic out_valid_reg, out_valid_next;
    res_t out_res_reg, out_res_next;
    logic skid_valid_reg, skid_valid_next;
    res_t skid_res_reg, skid_res_next;
    logic stall_push;

    assign res_ready = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    assign stall_push = res_valid && out_valid_reg && !out_ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_res_next    = out_res_reg;
        skid_valid_next = skid_valid_reg;
        skid_res_next   = skid_res_reg;
        if (!out_valid_reg || out_ready)
        begin
            // The skid entry is older than anything arriving now.
            out_valid_next  = skid_valid_reg || res_valid;
            out_res_next    = skid_valid_reg ? skid_res_reg : res;
            skid_valid_next = 1'b0;
        end
        else if (res_valid)
        begin
            skid_valid_next = 1'b1;
            skid_res_next   = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg  <= out_res_next;
        skid_res_reg <= skid_res_next;
    end

    `HEXP_ASSERT(a_skid_behind_out, clk, rst_n, skid_valid_reg |-> out_valid_reg)
    `HEXP_ASSERT(a_no_push_when_full, clk, rst_n, skid_valid_reg |-> !res_valid)
    `HEXP_ASSERT(a_stall_fills_skid, clk, rst_n, stall_push |=> skid_valid_reg)
    `HEXP_ASSERT(a_skid_drains, clk, rst_n, (skid_valid_reg && out_ready) |=> !skid_valid_reg)

endmodule

/* hdl/hex_text_table_parser.sv */
// Path: a transfer accepted on the slave side passes the input register, then the result
// register, before its result shows on the master side.
// Throughput: one character per cycle while the skid stage is empty; a stall on the master
// side reaches s_tready through the registered ready of the skid stage.
// Reset (rst_n low, asynchronous): parser back to expecting a high digit, no result pending.
// ----------------------------------------------------------------------------
// hex_text_table_parser
// Parses a text table of two-digit hex bytes, one ASCII character per transfer.
// ----------------------------------------------------------------------------
module hex_text_table_parser #(
    parameter int ENTRIES_PER_LINE = hexp_pkg::HEXP_ENTRIES_PER_LINE,
    parameter int TABLE_ENTRIES    = hexp_pkg::HEXP_TABLE_ENTRIES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic [1:0]  s_tuser,   // [1:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] byte_value, [15:8] entry_index
    output logic [1:0]  m_tuser    // [1:0] status
);
    import hexp_pkg::*;

    logic res_valid;
    logic res_ready;
    res_t res;
    res_t out_res;

    hexp_parse_core #(
        .ENTRIES_PER_LINE (ENTRIES_PER_LINE),
        .TABLE_ENTRIES    (TABLE_ENTRIES)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .kind      (s_tuser),
        .char_code (s_tdata),
        .out_ready (res_ready),
        .res_valid (res_valid),
        .res       (res)
    );

    hexp_out_buf u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {out_res.entry_index, out_res.byte_value};
    assign m_tuser = out_res.status;

endmodule
